>>> hw/rtl/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg: shared types and constants for the sorted key set
// Opcodes, status codes, transaction payloads and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

  // Default sizing
  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_KEY_WIDTH = 32;

  // Fixed field widths of the transaction payloads
  localparam int OPC_W = 3;
  localparam int KEYF_W = 32;
  localparam int IDX_W = 6;
  localparam int STAT_W = 3;
  localparam int POS_W = 7;

  // Request opcodes
  typedef enum logic [OPC_W-1:0] {
    OP_INSERT  = 3'd0,
    OP_ERASE   = 3'd1,
    OP_FIND    = 3'd2,
    OP_LOWER   = 3'd3,
    OP_UPPER   = 3'd4,
    OP_READ_AT = 3'd5,
    OP_CLEAR   = 3'd6
  } sks_op_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } sks_status_t;

  // Request payload
  typedef struct packed {
    logic [OPC_W-1:0]  opcode;
    logic [KEYF_W-1:0] key;
    logic [IDX_W-1:0]  index;
  } sks_in_t;

  // Result payload
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic              found;
    logic [KEYF_W-1:0] key_out;
    logic [POS_W-1:0]  length;
  } sks_out_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic ins;       // open a slot at the lower bound and drop the key in
    logic del;       // close the slot at the lower bound
    logic sign_ord;  // compare as two's complement
  } sks_cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/sks_cell.sv
// ----------------------------------------------------------------------------
// sks_cell: one entry of the sorted key chain
// Holds one key, compares it with the request key and shifts left or right
// with its neighbors on insert and erase.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_cell #(
  parameter int KEY_WIDTH = sks_pkg::DEF_KEY_WIDTH
) (
  input  wire logic                  clk,
  input  wire sks_pkg::sks_cell_ctl_t ctl,
  input  wire logic [KEY_WIDTH-1:0]  req_key,
  input  wire logic                  valid,    // entry holds a key
  input  wire logic                  open,     // entry is held or is the first free one
  input  wire logic                  below,    // entry lies before the lower bound
  input  wire logic                  lt_prev,  // left neighbor lies before the lower bound
  input  wire logic [KEY_WIDTH-1:0]  key_prev,
  input  wire logic [KEY_WIDTH-1:0]  key_next,
  output logic                       lt,
  output logic                       eq,
  output logic [KEY_WIDTH-1:0]       key_q
);

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;
  logic [KEY_WIDTH-1:0] flip;

  // Sign flip maps signed order onto unsigned order
  assign flip = {ctl.sign_ord, {(KEY_WIDTH-1){1'b0}}};

  // Compare
  assign lt = valid && ((key_r ^ flip) < (req_key ^ flip));
  assign eq = valid && (key_r == req_key);

  // Shift / load from the lower bound onward
  always_comb begin
    key_nxt = key_r;
    if (ctl.ins && open && !below) begin
      key_nxt = lt_prev ? req_key : key_prev;
    end else if (ctl.del && valid && !below) begin
      key_nxt = key_next;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule

`default_nettype wire

>>> hw/rtl/sorted_key_set.sv
// ----------------------------------------------------------------------------
// sorted_key_set: ordered set of unique keys held in a chain of cells
// Each cell keeps one key; all cells compare in parallel and shift together.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on in_valid/in_stall with payload in_data (opcode, key,
//   index); each request yields one result on out_valid/out_stall with
//   payload out_data. A transaction moves when valid is high and stall low.
//   cfg_valid/cfg_ready writes cfg_data into the signed_order register;
//   cfg_ready is always high. Write it only while the block is idle.
//   The request is registered first; then every cell compares its key
//   with it, the lower bound is counted from the less-than flags, the
//   cells shift in place and the result is registered. A new request is
//   not taken before the held one has executed: the request register
//   holds a transaction while the cell chain executes it.
//   A finished result waits in the output register while the next request
//   is accepted; that request executes once the output register frees.
//   Reset clears the key count and signed_order; there is no clearing
//   pass, stored keys are undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_set #(
  parameter int CAPACITY  = sks_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH = sks_pkg::DEF_KEY_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sks_pkg::sks_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sks_pkg::sks_out_t     out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int RDN = (CAPACITY < 64) ? CAPACITY : 64;
  localparam int IW  = (CW > sks_pkg::IDX_W) ? CW : sks_pkg::IDX_W;

  // Request register
  logic                         req_valid_r, req_valid_nxt;
  logic [sks_pkg::OPC_W-1:0]    req_op_r;
  logic [KEY_WIDTH-1:0]         req_key_r;
  logic [sks_pkg::IDX_W-1:0]    req_idx_r;
  logic [KEY_WIDTH-1:0]         in_key;

  // State
  logic [CW-1:0]                count_r, count_nxt;
  logic                         sign_ord_r;
  logic                         out_valid_r, out_valid_nxt;
  sks_pkg::sks_out_t            out_data_r, out_data_nxt;

  // Cell chain signals
  logic [CAPACITY-1:0]          lt_vec, eq_vec;
  logic [CAPACITY-1:0]          below_vec;
  logic [KEY_WIDTH-1:0]         cell_key [CAPACITY];
  sks_pkg::sks_cell_ctl_t       ctl;

  logic                         exec;
  logic                         found;
  logic [CW-1:0]                lo;
  logic [KEY_WIDTH-1:0]         rd_key;
  logic [sks_pkg::KEYF_W-1:0]   rd_key32;
  logic                         full;
  logic                         in_range;

  // Request key narrowed or widened to the stored key width
  generate
    if (KEY_WIDTH <= sks_pkg::KEYF_W) begin : g_key_narrow
      assign in_key   = in_data.key[KEY_WIDTH-1:0];
      assign rd_key32 = {{(sks_pkg::KEYF_W-KEY_WIDTH){1'b0}}, rd_key};
    end else begin : g_key_wide
      assign in_key   = {{(KEY_WIDTH-sks_pkg::KEYF_W){1'b0}}, in_data.key};
      assign rd_key32 = rd_key[sks_pkg::KEYF_W-1:0];
    end
  endgenerate

  // Handshakes
  assign in_stall  = req_valid_r;
  assign exec      = req_valid_r && (!out_valid_r || !out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    req_valid_nxt = req_valid_r;
    if (exec) begin
      req_valid_nxt = 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_op_r  <= in_data.opcode;
      req_key_r <= in_key;
      req_idx_r <= in_data.index;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sign_ord_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      sign_ord_r <= cfg_data;
    end
  end

  // Cell chain
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 c_lt_prev;
      logic [KEY_WIDTH-1:0] c_key_prev;
      logic [KEY_WIDTH-1:0] c_key_next;

      if (i == 0) begin : g_first
        assign c_lt_prev  = 1'b1;
        assign c_key_prev = req_key_r;
      end else begin : g_mid
        assign c_lt_prev  = below_vec[i-1];
        assign c_key_prev = cell_key[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign c_key_next = cell_key[i];
      end else begin : g_inner
        assign c_key_next = cell_key[i+1];
      end

      sks_cell #(
        .KEY_WIDTH (KEY_WIDTH)
      ) u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .req_key  (req_key_r),
        .valid    (CW'(i) < count_r),
        .open     (CW'(i) <= count_r),
        .below    (below_vec[i]),
        .lt_prev  (c_lt_prev),
        .key_prev (c_key_prev),
        .key_next (c_key_next),
        .lt       (lt_vec[i]),
        .eq       (eq_vec[i]),
        .key_q    (cell_key[i])
      );
    end
  endgenerate

  // Lower bound: number of held keys below the request key
  assign lo = CW'($countones(lt_vec));

  // Positions before the lower bound stay in place on insert and erase
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      below_vec[i] = CW'(i) < lo;
    end
  end

  assign found = |eq_vec;
  assign full  = (count_r == CW'(CAPACITY));

  // Read-at select
  always_comb begin
    rd_key = '0;
    for (int i = 0; i < RDN; i++) begin
      if (req_idx_r == sks_pkg::IDX_W'(i)) begin
        rd_key = rd_key | cell_key[i];
      end
    end
  end

  assign in_range = IW'(req_idx_r) < IW'(count_r);

  // Execute: cell control, count update and result
  always_comb begin
    ctl          = '0;
    ctl.sign_ord = sign_ord_r;
    count_nxt    = count_r;
    out_data_nxt = '0;
    case (sks_pkg::sks_op_t'(req_op_r))
      sks_pkg::OP_INSERT: begin
        out_data_nxt.position = sks_pkg::POS_W'(lo);
        if (found) begin
          out_data_nxt.status = sks_pkg::ST_DUPLICATE;
          out_data_nxt.found  = 1'b1;
        end else if (full) begin
          out_data_nxt.status = sks_pkg::ST_FULL;
        end else begin
          ctl.ins   = exec;
          count_nxt = count_r + CW'(1);
        end
      end
      sks_pkg::OP_ERASE: begin
        if (found) begin
          out_data_nxt.found    = 1'b1;
          out_data_nxt.position = sks_pkg::POS_W'(lo);
          ctl.del               = exec;
          count_nxt             = count_r - CW'(1);
        end else begin
          out_data_nxt.status   = sks_pkg::ST_NOT_FOUND;
          out_data_nxt.position = sks_pkg::POS_W'(count_r);
        end
      end
      sks_pkg::OP_FIND: begin
        out_data_nxt.found    = found;
        out_data_nxt.position = found ? sks_pkg::POS_W'(lo) : sks_pkg::POS_W'(count_r);
      end
      sks_pkg::OP_LOWER: begin
        out_data_nxt.found    = found;
        out_data_nxt.position = sks_pkg::POS_W'(lo);
      end
      sks_pkg::OP_UPPER: begin
        out_data_nxt.found    = found;
        out_data_nxt.position = sks_pkg::POS_W'(lo + CW'(found));
      end
      sks_pkg::OP_READ_AT: begin
        out_data_nxt.position = sks_pkg::POS_W'(req_idx_r);
        if (in_range) begin
          out_data_nxt.key_out = rd_key32;
        end else begin
          out_data_nxt.status = sks_pkg::ST_RANGE;
        end
      end
      sks_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    out_data_nxt.length = sks_pkg::POS_W'(count_nxt);
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (exec) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  // Count never exceeds the chain length
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("key count above capacity");

  // Lower bound never passes the key count
  a_lo_cap: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r |-> (lo <= count_r))
    else $error("lower bound above key count");

  // Keys stay unique: at most one cell matches
  a_eq_unique: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r |-> $onehot0(eq_vec))
    else $error("duplicate key held");

  // An executed request always presents a result next cycle
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> (out_valid_r && !req_valid_r))
    else $error("executed request produced no result");
`endif

endmodule

`default_nettype wire

>>> sim/sks_result_checker.sv
// ----------------------------------------------------------------------------
// sks_result_checker: result predictor and scoreboard for sorted_key_set
// Watches the request, result and configuration channels. Keeps its own copy
// of the key set and the order setting, computes the answer to every accepted
// request and compares each accepted result with the oldest open answer.
// ----------------------------------------------------------------------------
module sks_result_checker
  import sks_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  sks_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  sks_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic     cfg_data,
  output int       fail_count,
  output int       pending
);

  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the key set
  logic [KEYF_W-1:0] held_keys [CAPACITY];
  int                held_count;
  bit                signed_keys;

  // Answers waiting for their result transaction
  sks_out_t answer_q [$];
  int       requests_seen;
  int       results_seen;

  initial fail_count = 0;

  assign pending = requests_seen - results_seen;

  // One line per mismatch, printing capped to keep the log short
  task automatic report_mismatch(input string msg);
    if (fail_count < 100) begin
      $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, msg);
    end
    fail_count++;
  endtask

  // Signed order maps onto unsigned order by flipping the sign bit
  function automatic logic [KEYF_W-1:0] order_key(input logic [KEYF_W-1:0] k);
    return signed_keys ? (k ^ {1'b1, {(KEYF_W-1){1'b0}}}) : k;
  endfunction

  // Number of held keys below k; eq tells whether k itself is held
  function automatic int keys_below(input logic [KEYF_W-1:0] k, output bit eq);
    int n;
    n  = 0;
    eq = 1'b0;
    for (int i = 0; i < held_count; i++) begin
      if (order_key(held_keys[i]) < order_key(k)) begin
        n++;
      end else if (held_keys[i] == k) begin
        eq = 1'b1;
      end
    end
    return n;
  endfunction

  // Executes one request on the shadow set and returns its result
  function automatic sks_out_t apply_request(input sks_in_t req);
    sks_out_t r;
    int       lo;
    bit       eq;
    r = '0;
    case (req.opcode)
      OP_INSERT: begin
        lo = keys_below(req.key, eq);
        r.position = lo;
        if (eq) begin
          r.status = ST_DUPLICATE;
          r.found  = 1'b1;
        end else if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int i = held_count; i > lo; i--) held_keys[i] = held_keys[i-1];
          held_keys[lo] = req.key;
          held_count++;
        end
      end
      OP_ERASE: begin
        lo = keys_below(req.key, eq);
        if (eq) begin
          r.found    = 1'b1;
          r.position = lo;
          for (int i = lo; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
        end else begin
          r.status   = ST_NOT_FOUND;
          r.position = held_count;
        end
      end
      OP_FIND: begin
        lo = keys_below(req.key, eq);
        r.found    = eq;
        r.position = eq ? lo : held_count;
      end
      OP_LOWER: begin
        r.position = keys_below(req.key, eq);
        r.found    = eq;
      end
      OP_UPPER: begin
        lo = keys_below(req.key, eq);
        r.found    = eq;
        r.position = lo + int'(eq);
      end
      OP_READ_AT: begin
        r.position = req.index;
        if (int'(req.index) < held_count) r.key_out = held_keys[req.index];
        else r.status = ST_RANGE;
      end
      OP_CLEAR: begin
        held_count = 0;
      end
      default: begin
        // unused opcode: no effect, only the length is reported
      end
    endcase
    r.length = held_count;
    return r;
  endfunction

  // Channel monitor: results are checked before a same-cycle request is added
  always @(posedge clk) begin
    sks_out_t want;
    if (!rst_n) begin
      held_count    = 0;
      signed_keys   = 1'b0;
      answer_q.delete();
      requests_seen <= 0;
      results_seen  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          want = answer_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      out_data.position, want.position));
          if (out_data.found !== want.found)
            report_mismatch($sformatf("found %0b, expected %0b",
                                      out_data.found, want.found));
          if (out_data.key_out !== want.key_out)
            report_mismatch($sformatf("key_out %08h, expected %08h",
                                      out_data.key_out, want.key_out));
          if (out_data.length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d",
                                      out_data.length, want.length));
        end
        results_seen <= results_seen + 1;
      end
      if (cfg_valid && cfg_ready) signed_keys = cfg_data;
      if (in_valid && !in_stall) begin
        answer_q.push_back(apply_request(in_data));
        requests_seen <= requests_seen + 1;
      end
    end
  end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for sorted_key_set
// A directed opening covers empty, extreme-key, duplicate, miss, range and
// clear cases; random phases then alternate unsigned and signed key order
// with insert-heavy fill runs, random idling on both channels and one long
// result hold-off. Results are checked by sks_result_checker.
// ----------------------------------------------------------------------------
module testbench;

  import sks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OPC_W-1:0] OP_UNUSED   = 3'd7;
  localparam int               CYCLE_LIMIT = 400000;
  localparam int               PHASE_ITEMS = 275;
  localparam int               LONG_HOLD   = 80;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sks_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sks_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic     cfg_data = 1'b0;

  int fail_count;
  int pending;
  int cycle_cnt = 0;

  // Idling controls shared with the result side
  bit tx_idle_en   = 1'b0;
  bit rx_idle_en   = 1'b0;
  bit hold_request = 1'b0;

  logic [KEYF_W-1:0] key_pool [128];
  int                pool_size;

  sorted_key_set i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sks_result_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one request and returns at the edge that accepts it
  task automatic send_request(input logic [OPC_W-1:0] op, input logic [KEYF_W-1:0] key,
                              input logic [IDX_W-1:0] idx);
    sks_in_t req;
    req.opcode = op;
    req.key    = key;
    req.index  = idx;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // Writes the key order register; the block must be idle
  task automatic write_order(input logic value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // New key pool per phase, sign and wrap boundaries always present
  task automatic refill_pool(input int size);
    pool_size = size;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'h0000_0001;
    key_pool[5] = 32'hFFFF_FFFE;
    for (int i = 6; i < size; i++) key_pool[i] = $urandom;
  endtask

  // Mostly pool keys so that hits and duplicates are common
  function automatic logic [KEYF_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, pool_size - 1)];
    return $urandom;
  endfunction

  task automatic random_request(input bit fill_mode);
    int               r;
    logic [OPC_W-1:0] op;
    r = $urandom_range(0, 99);
    if (fill_mode) begin
      op = (r < 55) ? OP_INSERT : (r < 65) ? OP_ERASE : (r < 73) ? OP_FIND :
           (r < 81) ? OP_LOWER : (r < 89) ? OP_UPPER : (r < 99) ? OP_READ_AT : OP_UNUSED;
    end else begin
      op = (r < 35) ? OP_INSERT : (r < 55) ? OP_ERASE : (r < 65) ? OP_FIND :
           (r < 73) ? OP_LOWER : (r < 81) ? OP_UPPER : (r < 95) ? OP_READ_AT :
           (r < 97) ? OP_CLEAR : OP_UNUSED;
    end
    send_request(op, pick_key(), $urandom_range(0, 63));
  endtask

  // Stimulus and verdict
  initial begin
    bit phase_sign [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    bit phase_fill [6] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    int phase_pool [6] = '{24, 128, 48, 24, 128, 48};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_order(1'b0);

    // Directed: empty set, extreme keys, duplicate, misses, bounds, range
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_request(OP_FIND,    32'h0000_0000, 6'd0);
    send_request(OP_ERASE,   32'h0000_0005, 6'd0);
    send_request(OP_READ_AT, 32'h0000_0000, 6'd0);
    send_request(OP_LOWER,   32'h0000_0007, 6'd0);
    send_request(OP_INSERT,  32'hFFFF_FFFF, 6'd0);
    send_request(OP_INSERT,  32'h0000_0000, 6'd63);
    send_request(OP_INSERT,  32'h8000_0000, 6'd0);
    send_request(OP_INSERT,  32'h7FFF_FFFF, 6'd0);
    send_request(OP_INSERT,  32'h0000_0000, 6'd0);
    send_request(OP_FIND,    32'h7FFF_FFFF, 6'd0);
    send_request(OP_LOWER,   32'h8000_0000, 6'd0);
    send_request(OP_UPPER,   32'h8000_0000, 6'd0);
    send_request(OP_UPPER,   32'hFFFF_FFFF, 6'd0);
    send_request(OP_LOWER,   32'h0000_0001, 6'd0);
    send_request(OP_READ_AT, 32'h0000_0000, 6'd0);
    send_request(OP_READ_AT, 32'h0000_0000, 6'd3);
    send_request(OP_READ_AT, 32'h0000_0000, 6'd4);
    send_request(OP_READ_AT, 32'hFFFF_FFFF, 6'd63);
    send_request(OP_ERASE,   32'h8000_0000, 6'd0);
    send_request(OP_ERASE,   32'h1234_5678, 6'd0);
    send_request(OP_UNUSED,  32'hFFFF_FFFF, 6'd63);
    send_request(OP_CLEAR,   32'h0000_0000, 6'd0);
    send_request(OP_FIND,    32'hFFFF_FFFF, 6'd0);

    // Random phases; the set is emptied before the key order changes
    for (int p = 0; p < 6; p++) begin
      send_request(OP_CLEAR, $urandom, $urandom_range(0, 63));
      write_order(phase_sign[p]);
      refill_pool(phase_pool[p]);
      tx_idle_en = (p != 5);
      rx_idle_en = (p != 5);
      if (p == 1) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) random_request(phase_fill[p]);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
